// File: sv/ias_pkg.sv
package ias_pkg;

	localparam int ITEM_DEPTH = 32;
	localparam int ADDR_W     = $clog2(ITEM_DEPTH);
	localparam int CNT_W      = $clog2(ITEM_DEPTH + 1);
	localparam int WORD_W     = 32;

	typedef struct packed {
		logic signed [WORD_W-1:0] value;
		logic                     last;
	} in_item_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] sorted_value;
		logic                     last_res;
	} out_item_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [WORD_W-1:0] wdata;
		logic [ADDR_W-1:0] raddr;
	} ram_cmd_t;

	typedef struct packed {
		logic load;
		logic last_res;
	} out_load_t;

	typedef enum logic [6:0] {
		ST_LOAD  = 7'b0000001,
		ST_FETCH = 7'b0000010,
		ST_HOLD  = 7'b0000100,
		ST_CMP   = 7'b0001000,
		ST_PLACE = 7'b0010000,
		ST_ORD   = 7'b0100000,
		ST_OWAIT = 7'b1000000
	} state_t;

endpackage

// File: sv/ias_ram.sv
module ias_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: sv/ias_cmp.sv
module ias_cmp
	import ias_pkg::*;
(
	input  logic [WORD_W-1:0] a,
	input  logic [WORD_W-1:0] b,
	output logic              gt
);

	// two's complement compare, a > b
	assign gt = $signed(a) > $signed(b);

endmodule

// File: sv/ias_ctrl.sv
module ias_ctrl
	import ias_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  in_item_t          in_data,
	output logic              in_stall,
	input  logic [WORD_W-1:0] rd_data,
	input  logic              gt,
	input  logic              out_free,
	output ram_cmd_t          cmd,
	output logic [WORD_W-1:0] held,
	output out_load_t         out_ld
);

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [ADDR_W-1:0] k_q, k_d;
	logic [ADDR_W-1:0] pos_q, pos_d;
	logic [ADDR_W-1:0] idx_q, idx_d;
	logic [WORD_W-1:0] held_q, held_d;
	logic              full;
	logic [CNT_W-1:0]  count_inc;
	logic              k_done;
	logic              idx_done;

	assign full      = (count_q == CNT_W'(ITEM_DEPTH));
	assign count_inc = full ? count_q : count_q + 1'b1;
	assign k_done    = ((CNT_W'(k_q) + 1'b1) == count_q);
	assign idx_done  = ((CNT_W'(idx_q) + 1'b1) == count_q);
	assign held      = held_q;
	assign in_stall  = (state_q != ST_LOAD);

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		k_d       = k_q;
		pos_d     = pos_q;
		idx_d     = idx_q;
		held_d    = held_q;
		cmd.we    = 1'b0;
		cmd.waddr = count_q[ADDR_W-1:0];
		cmd.wdata = in_data.value;
		cmd.raddr = k_q;
		out_ld    = '0;
		unique case (state_q)
			ST_LOAD: begin
				if (in_valid) begin
					// drop the value once the store is full
					cmd.we  = !full;
					count_d = count_inc;
					if (in_data.last) begin
						idx_d = '0;
						k_d   = ADDR_W'(1);
						if (count_inc > CNT_W'(1)) begin
							state_d = ST_FETCH;
						end else begin
							state_d = ST_ORD;
						end
					end
				end
			end
			ST_FETCH: begin
				cmd.raddr = k_q;
				state_d   = ST_HOLD;
			end
			ST_HOLD: begin
				held_d    = rd_data;
				pos_d     = k_q;
				cmd.raddr = k_q - 1'b1;
				state_d   = ST_CMP;
			end
			ST_CMP: begin
				cmd.we = 1'b1;
				cmd.waddr = pos_q;
				if (gt) begin
					// shift the larger neighbor up one slot
					cmd.wdata = rd_data;
					pos_d     = pos_q - 1'b1;
					cmd.raddr = pos_q - 2'd2;
					if (pos_q == ADDR_W'(1)) begin
						state_d = ST_PLACE;
					end
				end else begin
					cmd.wdata = held_q;
					if (k_done) begin
						state_d = ST_ORD;
					end else begin
						k_d     = k_q + 1'b1;
						state_d = ST_FETCH;
					end
				end
			end
			ST_PLACE: begin
				cmd.we    = 1'b1;
				cmd.waddr = '0;
				cmd.wdata = held_q;
				if (k_done) begin
					state_d = ST_ORD;
				end else begin
					k_d     = k_q + 1'b1;
					state_d = ST_FETCH;
				end
			end
			ST_ORD: begin
				cmd.raddr = idx_q;
				if (out_free) begin
					state_d = ST_OWAIT;
				end
			end
			ST_OWAIT: begin
				out_ld.load     = 1'b1;
				out_ld.last_res = idx_done;
				if (idx_done) begin
					count_d = '0;
					state_d = ST_LOAD;
				end else begin
					idx_d   = idx_q + 1'b1;
					state_d = ST_ORD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			count_q <= '0;
			k_q     <= '0;
			pos_q   <= '0;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			k_q     <= k_d;
			pos_q   <= pos_d;
			idx_q   <= idx_d;
		end
	end

	always_ff @(posedge clk) begin
		held_q <= held_d;
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(ITEM_DEPTH))
		else $error("item count above store depth");

	a_no_write_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ORD || state_q == ST_OWAIT) |-> !cmd.we)
		else $error("store written while draining results");

	a_k_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FETCH || state_q == ST_HOLD || state_q == ST_CMP ||
		 state_q == ST_PLACE) |-> (CNT_W'(k_q) < count_q))
		else $error("insertion index past item count");

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CMP) |-> (pos_q <= k_q && pos_q != '0))
		else $error("insertion slot out of range");

	a_owait_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OWAIT) |-> $past(state_q == ST_ORD && out_free))
		else $error("result load without a free output register");

endmodule

// File: sv/integer_ascending_sorter.sv
// Ascending sorter for sets of up to 32 signed 32-bit integers.
//
// Input channel (in_valid / in_stall / in_data): one value per transfer.
// While loading, in_stall is low and a value is taken every cycle. The
// transfer with in_data.last set closes the set. Values past the 32nd of a
// set are dropped; a dropped value flagged last still closes the set.
// After the closing transfer, in_stall stays high while the set is sorted
// and emitted.
//
// Sort: insertion sort over one store with one shared compare unit. Each
// insertion shifts every larger neighbor up one slot and writes the value
// where the shifting stops, or in slot 0; a single value skips the sort.
//
// Output channel (out_valid / out_stall / out_data): sorted values, smallest
// first, each loaded once the output register is free; last_res marks the largest.
// A stall holds out_data and freezes the drain. Loading of the next set
// starts as soon as the last result sits in the output register.
//
// Reset (arst_n low) empties the set and the output register; store
// contents are not cleared and need not be.
module integer_ascending_sorter
	import ias_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data
);

	ram_cmd_t          cmd;
	logic [WORD_W-1:0] rd_data;
	logic [WORD_W-1:0] held;
	logic              gt;
	logic              out_free;
	out_load_t         out_ld;
	logic              out_valid_q;
	out_item_t         out_data_q;

	// output register is free when empty or being taken this cycle
	assign out_free = !out_valid_q || !out_stall;

	ias_ram #(
		.WIDTH(WORD_W),
		.DEPTH(ITEM_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (cmd.we),
		.waddr(cmd.waddr),
		.wdata(cmd.wdata),
		.raddr(cmd.raddr),
		.rdata(rd_data)
	);

	// shared compare: stored neighbor against the value being inserted
	ias_cmp u_cmp (
		.a (rd_data),
		.b (held),
		.gt(gt)
	);

	ias_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_data (in_data),
		.in_stall(in_stall),
		.rd_data (rd_data),
		.gt      (gt),
		.out_free(out_free),
		.cmd     (cmd),
		.held    (held),
		.out_ld  (out_ld)
	);

	// hold the result until transferred, load a new one from the store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ld.load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ld.load) begin
			out_data_q.sorted_value <= $signed(rd_data);
			out_data_q.last_res     <= out_ld.last_res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule
